// File: rtl/core/lru_pr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lru_pr_pkg;

	// defaults for the top level parameters
	localparam int FRAMES_DEF    = 32;
	localparam int PAGE_BITS_DEF = 16;

	// fixed field widths of the ports
	localparam int NUM_FRAMES_W  = 6;
	localparam int FRAME_INDEX_W = 5;
	localparam int EVICT_PAGE_W  = 16;
	localparam int FAULT_W       = 16;

	localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST = NUM_FRAMES_W'(32);
	localparam logic [FAULT_W-1:0]      FAULT_MAX      = {FAULT_W{1'b1}};

	// update broadcast to every cell at commit
	typedef enum logic [1:0] {
		UPD_HIT,
		UPD_FILL,
		UPD_EVICT
	} upd_op_t;

	// sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/lru_pr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One page frame: page, valid bit and recency rank. The lookup token is
// registered in it; the commit update reaches all cells at once.
module lru_pr_cell #(
	parameter int IDX       = 0,
	parameter int PAGE_BITS = 16,
	parameter int IDX_W     = 5,
	parameter int RANK_W    = 5
) (
	input  wire                      clk,
	input  wire                      arst_n,
	// token from the left neighbor
	input  wire                      tin_valid,
	input  wire  [PAGE_BITS-1:0]     tin_page,
	input  wire                      tin_found,
	input  wire  [IDX_W-1:0]         tin_hit_idx,
	input  wire  [RANK_W-1:0]        tin_hit_rank,
	input  wire  [IDX_W-1:0]         tin_vic_idx,
	input  wire  [PAGE_BITS-1:0]     tin_vic_page,
	// token to the right neighbor
	output logic                     tout_valid,
	output logic [PAGE_BITS-1:0]     tout_page,
	output logic                     tout_found,
	output logic [IDX_W-1:0]         tout_hit_idx,
	output logic [RANK_W-1:0]        tout_hit_rank,
	output logic [IDX_W-1:0]         tout_vic_idx,
	output logic [PAGE_BITS-1:0]     tout_vic_page,
	// rank held by the least recent frame
	input  wire  [RANK_W-1:0]        vic_rank,
	// commit broadcast
	input  wire                      upd_en,
	input  wire lru_pr_pkg::upd_op_t upd_op,
	input  wire  [IDX_W-1:0]         upd_slot,
	input  wire  [RANK_W-1:0]        upd_rank,
	input  wire  [PAGE_BITS-1:0]     upd_page
);
	import lru_pr_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [PAGE_BITS-1:0] frame_page_q;
	logic                 frame_valid_q;
	logic [RANK_W-1:0]    frame_rank_q;
	logic                 hit_here;
	logic                 vic_here;
	logic                 is_slot;

	// first matching frame wins; the victim is the frame at the oldest rank
	assign hit_here = frame_valid_q && (frame_page_q == tin_page) && !tin_found;
	assign vic_here = frame_valid_q && (frame_rank_q == vic_rank);
	assign is_slot  = (upd_slot == MY_IDX);

	// token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_valid <= 1'b0;
		end else begin
			tout_valid <= tin_valid;
		end
	end

	always_ff @(posedge clk) begin
		tout_page     <= tin_page;
		tout_found    <= tin_found | hit_here;
		tout_hit_idx  <= hit_here ? MY_IDX : tin_hit_idx;
		tout_hit_rank <= hit_here ? frame_rank_q : tin_hit_rank;
		tout_vic_idx  <= vic_here ? MY_IDX : tin_vic_idx;
		tout_vic_page <= vic_here ? frame_page_q : tin_vic_page;
	end

	// valid and rank update at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
			frame_rank_q  <= '0;
		end else if (upd_en) begin
			if (is_slot && upd_op != UPD_HIT) begin
				frame_valid_q <= 1'b1;
				frame_rank_q  <= '0;
			end else if (is_slot) begin
				frame_rank_q <= '0;
			end else begin
				case (upd_op)
					UPD_HIT: begin
						if (frame_valid_q && frame_rank_q < upd_rank)
							frame_rank_q <= frame_rank_q + RANK_W'(1);
					end
					default: begin
						if (frame_valid_q)
							frame_rank_q <= frame_rank_q + RANK_W'(1);
					end
				endcase
			end
		end
	end

	// page store, written on fill or eviction
	always_ff @(posedge clk) begin
		if (upd_en && is_slot && upd_op != UPD_HIT)
			frame_page_q <= upd_page;
	end

endmodule

`default_nettype wire

// File: rtl/core/lru_page_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none

// LRU page replacement over FRAMES fully associative frames. Pulse start
// with page_id while busy is low; the reference walks a row of frame cells,
// one cell per cycle, then a commit updates all frames. done pulses for
// exactly one cycle once the commit result is registered, carrying hit,
// frame_index, evicted_valid, evicted_page and fault_count; there is no
// backpressure, so the receiver must take the result in that cycle. busy
// drops in the cycle done is high, so the next start transfer lands at the
// end of that cycle; the core takes no new reference while one is still
// walking the cell row.
// cfg_we/cfg_data write num_frames (0 acts as 1, above FRAMES acts as
// FRAMES) and must be used only while busy is low. After reset all frames
// are empty, num_frames is 32 and the fault count is zero.
module lru_page_replacement_core #(
	parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	output logic                                    busy,
	input  wire  [PAGE_BITS-1:0]                    page_id,
	input  wire                                     cfg_we,
	input  wire  [lru_pr_pkg::NUM_FRAMES_W-1:0]     cfg_data,
	output logic                                    done,
	output logic                                    hit,
	output logic [lru_pr_pkg::FRAME_INDEX_W-1:0]    frame_index,
	output logic                                    evicted_valid,
	output logic [lru_pr_pkg::EVICT_PAGE_W-1:0]     evicted_page,
	output logic [lru_pr_pkg::FAULT_W-1:0]          fault_count
);
	import lru_pr_pkg::*;

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int USED_W = $clog2(FRAMES + 1);
	localparam int CMP_W  = (USED_W > NUM_FRAMES_W) ? USED_W : NUM_FRAMES_W;
	localparam int IXE_W  = (IDX_W > FRAME_INDEX_W) ? IDX_W : FRAME_INDEX_W;
	localparam int PGE_W  = (PAGE_BITS > EVICT_PAGE_W) ? PAGE_BITS : EVICT_PAGE_W;

	state_t state_q, state_d;

	logic [NUM_FRAMES_W-1:0] num_frames_q;
	logic [USED_W-1:0]       used_q;
	logic [FAULT_W-1:0]      faults_q;
	logic [PAGE_BITS-1:0]    page_q;
	logic                    tok_start_q;

	// token chain, entry 0 is driven here, entry FRAMES leaves the last cell
	logic                 tok_valid    [FRAMES+1];
	logic [PAGE_BITS-1:0] tok_page     [FRAMES+1];
	logic                 tok_found    [FRAMES+1];
	logic [IDX_W-1:0]     tok_hit_idx  [FRAMES+1];
	logic [RANK_W-1:0]    tok_hit_rank [FRAMES+1];
	logic [IDX_W-1:0]     tok_vic_idx  [FRAMES+1];
	logic [PAGE_BITS-1:0] tok_vic_page [FRAMES+1];

	logic                 accept;
	logic                 commit;
	logic [RANK_W-1:0]    vic_rank;
	logic [CMP_W-1:0]     nf_ext;
	logic [CMP_W-1:0]     limit;
	logic                 full;
	upd_op_t              upd_op;
	logic [IDX_W-1:0]     upd_slot;
	logic [IXE_W-1:0]     slot_ext;
	logic [PGE_W-1:0]     vic_ext;

	logic                     hit_q;
	logic [FRAME_INDEX_W-1:0] frame_index_q;
	logic                     ev_valid_q;
	logic [EVICT_PAGE_W-1:0]  ev_page_q;
	logic                     done_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (tok_valid[FRAMES]) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_SCAN: begin
				busy   = 1'b1;
				commit = tok_valid[FRAMES];
			end
			default: busy = 1'b0;
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= NUM_FRAMES_RST;
		end else if (cfg_we) begin
			num_frames_q <= cfg_data;
		end
	end

	// token launch into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_start_q <= 1'b0;
		end else begin
			tok_start_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			page_q <= page_id;
	end

	assign tok_valid[0]    = tok_start_q;
	assign tok_page[0]     = page_q;
	assign tok_found[0]    = 1'b0;
	assign tok_hit_idx[0]  = '0;
	assign tok_hit_rank[0] = '0;
	assign tok_vic_idx[0]  = '0;
	assign tok_vic_page[0] = '0;

	// the oldest valid frame holds rank used-1
	assign vic_rank = RANK_W'(used_q - USED_W'(1));

	// row of frame cells
	for (genvar gi = 0; gi < FRAMES; gi++) begin : g_cell
		lru_pr_cell #(
			.IDX       (gi),
			.PAGE_BITS (PAGE_BITS),
			.IDX_W     (IDX_W),
			.RANK_W    (RANK_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.tin_valid     (tok_valid[gi]),
			.tin_page      (tok_page[gi]),
			.tin_found     (tok_found[gi]),
			.tin_hit_idx   (tok_hit_idx[gi]),
			.tin_hit_rank  (tok_hit_rank[gi]),
			.tin_vic_idx   (tok_vic_idx[gi]),
			.tin_vic_page  (tok_vic_page[gi]),
			.tout_valid    (tok_valid[gi+1]),
			.tout_page     (tok_page[gi+1]),
			.tout_found    (tok_found[gi+1]),
			.tout_hit_idx  (tok_hit_idx[gi+1]),
			.tout_hit_rank (tok_hit_rank[gi+1]),
			.tout_vic_idx  (tok_vic_idx[gi+1]),
			.tout_vic_page (tok_vic_page[gi+1]),
			.vic_rank      (vic_rank),
			.upd_en        (commit),
			.upd_op        (upd_op),
			.upd_slot      (upd_slot),
			.upd_rank      (tok_hit_rank[FRAMES]),
			.upd_page      (page_q)
		);
	end

	// clamp the frame limit to 1..FRAMES
	assign nf_ext = CMP_W'(num_frames_q);
	always_comb begin
		if (nf_ext == '0)
			limit = CMP_W'(1);
		else if (nf_ext > CMP_W'(FRAMES))
			limit = CMP_W'(FRAMES);
		else
			limit = nf_ext;
	end

	assign full = CMP_W'(used_q) >= limit;

	// commit decision: hit, fill the lowest free frame, or evict the oldest
	always_comb begin
		if (tok_found[FRAMES]) begin
			upd_op   = UPD_HIT;
			upd_slot = tok_hit_idx[FRAMES];
		end else if (full) begin
			upd_op   = UPD_EVICT;
			upd_slot = tok_vic_idx[FRAMES];
		end else begin
			upd_op   = UPD_FILL;
			upd_slot = IDX_W'(used_q);
		end
	end

	assign slot_ext = IXE_W'(upd_slot);
	assign vic_ext  = PGE_W'(tok_vic_page[FRAMES]);

	// frame count and fault counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			faults_q <= '0;
		end else if (commit) begin
			if (upd_op == UPD_FILL)
				used_q <= used_q + USED_W'(1);
			if (!tok_found[FRAMES] && faults_q != FAULT_MAX)
				faults_q <= faults_q + FAULT_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= commit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q         <= tok_found[FRAMES];
			frame_index_q <= slot_ext[FRAME_INDEX_W-1:0];
			ev_valid_q    <= (upd_op == UPD_EVICT);
			ev_page_q     <= (upd_op == UPD_EVICT) ? vic_ext[EVICT_PAGE_W-1:0] : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = faults_q;

endmodule

`default_nettype wire

// File: rtl/core/lru_pr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port level checks for the page replacement core.
module lru_pr_checker #(
	parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  start,
	input wire                                  busy,
	input wire [PAGE_BITS-1:0]                  page_id,
	input wire                                  cfg_we,
	input wire [lru_pr_pkg::NUM_FRAMES_W-1:0]   cfg_data,
	input wire                                  done,
	input wire                                  hit,
	input wire [lru_pr_pkg::FRAME_INDEX_W-1:0]  frame_index,
	input wire                                  evicted_valid,
	input wire [lru_pr_pkg::EVICT_PAGE_W-1:0]   evicted_page,
	input wire [lru_pr_pkg::FAULT_W-1:0]        fault_count
);

	// a start transfer keeps the core busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after a start transfer");

	// a hit never replaces a page
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evicted_valid)
		else $error("eviction reported on a hit");

	// no eviction means evicted_page reads zero
	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted_valid |-> evicted_page == '0)
		else $error("evicted_page nonzero without eviction");

	// fault count moves only with a result transfer
	a_fault_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fault_count) |-> done && !hit)
		else $error("fault count changed outside a fault result");

	// a hit leaves the fault count alone
	a_hit_keeps_faults: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> fault_count == $past(fault_count))
		else $error("fault count changed on a hit");

endmodule

bind lru_page_replacement_core lru_pr_checker #(
	.FRAMES    (FRAMES),
	.PAGE_BITS (PAGE_BITS)
) u_lru_pr_checker (.*);

`default_nettype wire
